FILE: rtl/rpn_pkg.sv
// shared types and constants for the rpn stack calculator
`default_nettype none
package rpn_pkg;
	localparam int StackDepth = 64;
	localparam int AddrW = $clog2(StackDepth);
	localparam int CountW = $clog2(StackDepth + 1);
	localparam int QueueDepth = 2;

	typedef enum logic [3:0] {
		REQ_PUSH  = 4'd0,
		REQ_ADD   = 4'd1,
		REQ_SUB   = 4'd2,
		REQ_MUL   = 4'd3,
		REQ_DIV   = 4'd4,
		REQ_NEG   = 4'd5,
		REQ_DUP   = 4'd6,
		REQ_SWAP  = 4'd7,
		REQ_PEEK  = 4'd8,
		REQ_CLEAR = 4'd9,
		REQ_DUMP  = 4'd10,
		REQ_QUIT  = 4'd11,
		REQ_BAD   = 4'd12
	} req_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_FEW  = 3'd1,
		ST_DIVZ = 3'd2,
		ST_FULL = 3'd3,
		ST_BADR = 3'd4
	} status_t;

	// classified request passed from front to back
	typedef struct packed {
		req_t        op;
		logic [31:0] push_value;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_WR1, S_WR2, S_DUMPRD, S_DUMPOUT, S_OUT
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/rpn_front.sv
// front end: accepts requests, classifies codes, holds a short queue
`default_nettype none
module rpn_front import rpn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  in_req,
	input  wire logic [31:0] in_value,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output cmd_t             cmd
);
	localparam int PtrW = $clog2(QueueDepth);
	cmd_t            fifo_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]   fill_q;
	cmd_t            cls;
	logic            push, pop;

	always_comb begin
		cls.push_value = in_value;
		if (in_req > 4'(REQ_QUIT)) cls.op = REQ_BAD;
		else cls.op = req_t'(in_req);
	end

	assign in_ready  = (fill_q != (PtrW+1)'(QueueDepth));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			fill_q <= fill_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (PtrW+1)'(QueueDepth)) else $error("queue overfill");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> !push) else $error("push into full queue");
	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> fill_q == $past(fill_q) + 1'b1) else $error("fill count slip");
endmodule
`default_nettype wire

FILE: rtl/rpn_divider.sv
// iterative signed 32-bit divider, one quotient bit a cycle
`default_nettype none
module rpn_divider import rpn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [31:0]      quotient
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        neg_q, busy_q, done_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted  = {rem_q, quo_q[31]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rpn_back.sv
// back end: stack memory and sequencer that carries out requests
`default_nettype none
module rpn_back import rpn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       out_status,
	output logic [31:0]      out_value,
	output logic             out_has,
	output logic             out_last
);
	logic [31:0]       mem_q [StackDepth];
	logic [31:0]       rd_q, a_q, b_q, r_q;
	logic [AddrW-1:0]  rd_addr;
	logic              rd_en;
	logic [AddrW-1:0]  wr_addr;
	logic [31:0]       wr_data;
	logic              wr_en;
	logic [CountW-1:0] count_q, idx_q;
	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic              div_start, div_busy, div_done;
	logic [31:0]       div_quo;
	logic [31:0]       prod;
	logic              ov_q, oh_q, ol_q;
	logic [2:0]        os_q;
	logic [31:0]       oval_q;
	logic              emit;
	logic [2:0]        e_status;
	logic [31:0]       e_value;
	logic              e_has, e_last;
	logic              take;
	logic [CountW-1:0] cnt_d;
	logic              r_ld;
	logic [31:0]       r_d;
	logic              a_ld, b_ld;
	logic [CountW-1:0] idx_d;

	rpn_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(a_q), .divisor(b_q),
		.busy(div_busy), .done(div_done), .quotient(div_quo)
	);

	// only the low word of the product is kept
	assign prod = a_q * b_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem_q[rd_addr];
		if (a_ld) a_q <= rd_q;
		if (b_ld) b_q <= rd_q;
		if (r_ld) r_q <= r_d;
		if (take) cmd_q <= cmd;
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign out_valid = ov_q;
	assign out_status = os_q;
	assign out_value = oval_q;
	assign out_has   = oh_q;
	assign out_last  = ol_q;

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		emit      = 1'b0;
		e_status  = ST_OK;
		e_value   = '0;
		e_has     = 1'b0;
		e_last    = 1'b1;
		cnt_d     = count_q;
		div_start = 1'b0;
		r_ld      = 1'b0;
		r_d       = '0;
		a_ld      = 1'b0;
		b_ld      = 1'b0;
		idx_d     = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					idx_d = count_q;
					unique case (cmd.op)
						REQ_PUSH: begin
							if (count_q == CountW'(StackDepth)) begin
								r_ld = 1'b1; r_d = 32'(ST_FULL);
							end else begin
								wr_en = 1'b1; wr_addr = count_q[AddrW-1:0];
								wr_data = cmd.push_value; cnt_d = count_q + 1'b1;
								r_ld = 1'b1; r_d = 32'(ST_OK);
							end
							state_d = S_OUT;
						end
						REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_SWAP: begin
							if (count_q < CountW'(2)) begin
								r_ld = 1'b1; r_d = 32'(ST_FEW); state_d = S_OUT;
							end else begin
								rd_en = 1'b1; rd_addr = AddrW'(count_q - 2'd2);
								state_d = S_RD1;
							end
						end
						REQ_NEG, REQ_DUP, REQ_PEEK: begin
							if (count_q == '0) begin
								r_ld = 1'b1; r_d = 32'(ST_FEW); state_d = S_OUT;
							end else if (cmd.op == REQ_DUP && count_q == CountW'(StackDepth)) begin
								r_ld = 1'b1; r_d = 32'(ST_FULL); state_d = S_OUT;
							end else begin
								rd_en = 1'b1; rd_addr = AddrW'(count_q - 1'b1);
								state_d = S_RD2;
							end
						end
						REQ_CLEAR, REQ_QUIT: begin
							cnt_d = '0; r_ld = 1'b1; r_d = 32'(ST_OK); state_d = S_OUT;
						end
						REQ_DUMP: begin
							if (count_q == '0) begin
								r_ld = 1'b1; r_d = 32'(ST_OK); state_d = S_OUT;
							end else begin
								rd_en = 1'b1; rd_addr = AddrW'(count_q - 1'b1);
								state_d = S_DUMPRD;
							end
						end
						default: begin
							r_ld = 1'b1; r_d = 32'(ST_BADR); state_d = S_OUT;
						end
					endcase
				end
			end
			S_RD1: begin
				// entry below the top is in rd_q; the top is read next
				a_ld = 1'b1;
				rd_en = 1'b1; rd_addr = AddrW'(count_q - 1'b1);
				state_d = S_RD2;
			end
			S_RD2: begin
				b_ld = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				// rd_q now holds top for binary ops; b_q for unary
				case (cmd_q.op)
					REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_SWAP: begin
						b_ld = 1'b1; state_d = S_WR1;
					end
					REQ_NEG: begin
						wr_en = 1'b1; wr_addr = AddrW'(count_q - 1'b1);
						wr_data = 32'd0 - b_q; r_ld = 1'b1; r_d = 32'(ST_OK);
						state_d = S_OUT;
					end
					REQ_DUP: begin
						wr_en = 1'b1; wr_addr = count_q[AddrW-1:0]; wr_data = b_q;
						cnt_d = count_q + 1'b1; r_ld = 1'b1; r_d = 32'(ST_OK);
						state_d = S_OUT;
					end
					default: begin
						emit = 1'b1; e_value = b_q; e_has = 1'b1;
						state_d = S_IDLE;
						if (ov_q && !out_ready) state_d = S_EXEC;
					end
				endcase
			end
			S_WR1: begin
				case (cmd_q.op)
					REQ_ADD: begin
						wr_en = 1'b1; wr_addr = AddrW'(count_q - 2'd2);
						wr_data = a_q + b_q; cnt_d = count_q - 1'b1;
						r_ld = 1'b1; r_d = 32'(ST_OK); state_d = S_OUT;
					end
					REQ_SUB: begin
						wr_en = 1'b1; wr_addr = AddrW'(count_q - 2'd2);
						wr_data = a_q - b_q; cnt_d = count_q - 1'b1;
						r_ld = 1'b1; r_d = 32'(ST_OK); state_d = S_OUT;
					end
					REQ_MUL: begin
						r_ld = 1'b1; r_d = prod; state_d = S_WR2;
					end
					REQ_DIV: begin
						if (b_q == '0) begin
							r_ld = 1'b1; r_d = 32'(ST_DIVZ); state_d = S_OUT;
						end else begin
							div_start = 1'b1; state_d = S_DIV;
						end
					end
					default: begin
						// swap: write old top below
						wr_en = 1'b1; wr_addr = AddrW'(count_q - 2'd2); wr_data = b_q;
						state_d = S_WR2;
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					r_ld = 1'b1; r_d = div_quo; state_d = S_WR2;
				end
			end
			S_WR2: begin
				if (cmd_q.op == REQ_SWAP) begin
					wr_en = 1'b1; wr_addr = AddrW'(count_q - 1'b1); wr_data = a_q;
				end else begin
					wr_en = 1'b1; wr_addr = AddrW'(count_q - 2'd2); wr_data = r_q;
					cnt_d = count_q - 1'b1;
				end
				r_ld = 1'b1; r_d = 32'(ST_OK); state_d = S_OUT;
			end
			S_DUMPRD: begin
				state_d = S_DUMPOUT;
			end
			S_DUMPOUT: begin
				if (!ov_q || out_ready) begin
					emit = 1'b1; e_value = rd_q; e_has = 1'b1;
					e_last = (idx_q == CountW'(1));
					if (idx_q == CountW'(1)) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q - 1'b1;
						rd_en = 1'b1; rd_addr = AddrW'(idx_q - 2'd2);
						state_d = S_DUMPRD;
					end
				end
			end
			S_OUT: begin
				if (!ov_q || out_ready) begin
					emit = 1'b1; e_status = r_q[2:0]; state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_EXEC && cmd_q.op == REQ_PEEK && ov_q && !out_ready) emit = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			os_q   <= e_status;
			oval_q <= e_value;
			oh_q   <= e_has;
			ol_q   <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= cnt_d;
			idx_q   <= idx_d;
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(StackDepth)) else $error("stack count overflow");
	a_div_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_DIV) else $error("divider busy outside divide");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!ov_q || out_ready)) else $error("result overwritten");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd_ready) else $error("accept while busy");
endmodule
`default_nettype wire

FILE: rtl/rpn_stack_calculator.sv
// top level of the rpn stack calculator
// sequencer: push, clear and errors found at once go straight to S_OUT;
//   peek, neg and dup read the top; add, sub, mul, div and swap read two entries
// dump: entries go out top first, read in S_DUMPRD, sent in S_DUMPOUT; output stalls wait there
// throughput: one request at a time in the back end; a two-entry queue takes requests meanwhile
// reset (arst_n low) empties the stack and queue; stack memory is not cleared
`default_nettype none
module rpn_stack_calculator import rpn_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // [3:0] req_type, [35:4] push_value, [39:36] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // [2:0] status, [34:3] value, [35] has_value, zero above
	output logic             m_tlast
);
	logic        cmd_valid, cmd_ready;
	cmd_t        cmd;
	logic [2:0]  st;
	logic [31:0] val;
	logic        has;

	rpn_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_req(s_tdata[3:0]), .in_value(s_tdata[35:4]),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	rpn_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .out_valid(m_tvalid), .out_ready(m_tready), .out_status(st),
		.out_value(val), .out_has(has), .out_last(m_tlast)
	);

	assign m_tdata = {4'd0, has, val, st};
endmodule
`default_nettype wire
